// ===== rtl/q2e_pkg.sv =====
// Shared types and constants for the quaternion to Z-Y-X Euler angle converter.
// Holds the CORDIC arctangent table and the pipeline stage counts.
// Depends on nothing.
package q2e_pkg;

    localparam int WORK_BITS    = 30;
    localparam int CORDIC_STEPS = 31;
    localparam int ISQRT_STEPS  = WORK_BITS + 1;
    localparam int CORDIC_W     = 34;
    localparam int ANGLE_W      = 34;
    localparam int ATAN_LAT     = 4 + CORDIC_STEPS + 2;

    typedef logic [WORK_BITS-1:0] atan_entry_t;
    typedef atan_entry_t atan_tab_t [CORDIC_STEPS];

    // atan(2^-i) in units of 2^-32 of a full turn
    localparam atan_tab_t ATAN_TURN = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
    };

    localparam logic signed [ANGLE_W-1:0] TURN_QUARTER = ANGLE_W'(64'd1 << 30);

endpackage

// ===== rtl/q2e_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [2*WORK_BITS:0]   n_in,
    output logic [WORK_BITS:0]     root_out
);

    localparam int NW = 2 * WORK_BITS + 2;

    logic [NW-1:0] n_reg [ISQRT_STEPS];
    logic [NW-1:0] r_reg [ISQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
            localparam logic [NW-1:0] BIT = NW'(1) << (2 * WORK_BITS - 2 * k);
            logic [NW-1:0] n_cur, r_cur, t, n_next, r_next;
            if (k == 0) begin : g_first
                assign n_cur = NW'(n_in);
                assign r_cur = '0;
            end else begin : g_rest
                assign n_cur = n_reg[k-1];
                assign r_cur = r_reg[k-1];
            end
            always_comb begin
                t = r_cur + BIT;
                if (n_cur >= t) begin
                    n_next = n_cur - t;
                    r_next = (r_cur >> 1) + BIT;
                end else begin
                    n_next = n_cur;
                    r_next = r_cur >> 1;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[k] <= n_next;
                    r_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign root_out = r_reg[ISQRT_STEPS-1][WORK_BITS:0];

endmodule

// ===== rtl/q2e_atan2.sv =====
// Pipelined atan2 with operand normalisation, vectoring CORDIC and conversion to degrees.
// Depends on q2e_pkg.
module q2e_atan2 import q2e_pkg::*; #(
    parameter int IN_W            = 35,
    parameter int OUT_W           = 16,
    parameter int LIM_DEG         = 180,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  y_in,
    input  logic signed [IN_W-1:0]  x_in,
    output logic [OUT_W-1:0]        angle_out
);

    localparam int POS_W = $clog2(IN_W);
    localparam int PRD_W = ANGLE_W + 10;
    localparam int PW    = PRD_W + ANGLE_FRAC_BITS;
    localparam int RW    = PW - 32;
    localparam logic signed [RW-1:0] LIM = RW'(longint'(LIM_DEG) << ANGLE_FRAC_BITS);

    // Stage 1: magnitudes and signs
    logic [IN_W-1:0] ux_reg, uy_reg, ux2_reg, uy2_reg;
    logic            xn_reg, yn_reg, xn2_reg, yn2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg <= x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
            uy_reg <= y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
            xn_reg <= x_in[IN_W-1];
            yn_reg <= y_in[IN_W-1];
        end
    end

    // Stage 2: leading-one position of the larger magnitude
    logic [IN_W-1:0]  orw;
    logic [POS_W-1:0] pos_next, pos_reg;
    logic             zero2_reg;

    always_comb begin
        orw      = ux_reg | uy_reg;
        pos_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (orw[i]) pos_next = POS_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg   <= pos_next;
            zero2_reg <= (orw == '0);
            ux2_reg   <= ux_reg;
            uy2_reg   <= uy_reg;
            xn2_reg   <= xn_reg;
            yn2_reg   <= yn_reg;
        end
    end

    // Stage 3: shift so that the larger magnitude lies in [2^29, 2^30)
    logic [IN_W-1:0]      sx, sy;
    logic [WORK_BITS-1:0] nx_reg, ny_reg;
    logic                 xn3_reg, yn3_reg, zero3_reg;

    always_comb begin
        if (int'(pos_reg) >= WORK_BITS) begin
            sx = ux2_reg >> (int'(pos_reg) - (WORK_BITS - 1));
            sy = uy2_reg >> (int'(pos_reg) - (WORK_BITS - 1));
        end else begin
            sx = ux2_reg << ((WORK_BITS - 1) - int'(pos_reg));
            sy = uy2_reg << ((WORK_BITS - 1) - int'(pos_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg    <= sx[WORK_BITS-1:0];
            ny_reg    <= sy[WORK_BITS-1:0];
            xn3_reg   <= xn2_reg;
            yn3_reg   <= yn2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // Stage 4: bring the left half-plane over by a quarter turn
    logic signed [CORDIC_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0]  z_reg  [CORDIC_STEPS+1];
    logic                       zero_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] px, py;

    always_comb begin
        px = xn3_reg ? -CORDIC_W'(nx_reg) : CORDIC_W'(nx_reg);
        py = yn3_reg ? -CORDIC_W'(ny_reg) : CORDIC_W'(ny_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= zero3_reg;
            if (px < 0) begin
                if (py >= 0) begin
                    cx_reg[0] <= py;
                    cy_reg[0] <= -px;
                    z_reg[0]  <= TURN_QUARTER;
                end else begin
                    cx_reg[0] <= -py;
                    cy_reg[0] <= px;
                    z_reg[0]  <= -TURN_QUARTER;
                end
            end else begin
                cx_reg[0] <= px;
                cy_reg[0] <= py;
                z_reg[0]  <= '0;
            end
        end
    end

    // CORDIC iterations, one per stage
    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_iter
            localparam logic signed [ANGLE_W-1:0] ANG = ANGLE_W'(ATAN_TURN[k]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[k+1] <= zero_reg[k];
                    if (cy_reg[k] > 0) begin
                        cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                        cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                        z_reg[k+1]  <= z_reg[k] + ANG;
                    end else begin
                        cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                        cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                        z_reg[k+1]  <= z_reg[k] - ANG;
                    end
                end
            end
        end
    endgenerate

    // Turn units to degrees: scale by 360, round, clamp
    logic signed [PRD_W-1:0] prod_reg;
    logic                    zero_p_reg;
    logic signed [PW-1:0]    v;
    logic signed [RW-1:0]    r;
    logic [OUT_W-1:0]        angle_reg;

    always_comb begin
        v = (PW'(prod_reg) <<< ANGLE_FRAC_BITS) + (PW'(1) <<< 31);
        r = v[PW-1:32];
        if (r > LIM) r = LIM;
        if (r < -LIM) r = -LIM;
        if (zero_p_reg) r = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= PRD_W'(z_reg[CORDIC_STEPS]) * PRD_W'(360);
            zero_p_reg <= zero_reg[CORDIC_STEPS];
            angle_reg  <= OUT_W'(r);
        end
    end

    assign angle_out = angle_reg;

endmodule

// ===== rtl/quaternion_to_euler_zyx.sv =====
// Throughput: one request per cycle; the whole pipeline advances together and holds
// while a finished result waits for m_tready, so nothing is lost or repeated.
// The depth is set by the 31-stage square root on the pitch path followed by the
// 37-stage atan2 unit (normalisation, 31 CORDIC stages, degree conversion).
// Reset: aresetn is synchronous and active low; it clears only the valid bits.
module quaternion_to_euler_zyx import q2e_pkg::*; #(
    parameter int QUAT_FRAC_BITS  = 14,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // yaw_angle[15:0], pitch_angle[30:16], roll_angle[46:31], zero
    output logic        m_tuser    // pitch_saturated[0]
);

    // The cosine terms hold 1.0 with twice the quaternion fraction bits, so the sum
    // width follows the quaternion format.
    localparam int SUM_W = (2 * QUAT_FRAC_BITS + 3 > 35) ? 2 * QUAT_FRAC_BITS + 3 : 35;
    localparam int SH_R  = (2 * QUAT_FRAC_BITS >= WORK_BITS) ? 2 * QUAT_FRAC_BITS - WORK_BITS : 0;
    localparam int SH_L  = (2 * QUAT_FRAC_BITS < WORK_BITS) ? WORK_BITS - 2 * QUAT_FRAC_BITS : 0;
    localparam int DELAY_RY = 3 + ISQRT_STEPS;
    localparam int DELAY_SAT = ISQRT_STEPS + ATAN_LAT;
    localparam int LAT = 2 + DELAY_RY + ATAN_LAT;
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic [14:0] PITCH_LIM = 15'(longint'(90) << ANGLE_FRAC_BITS);

    // The whole pipeline moves whenever the output register is empty or being drained.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [LAT-1:0] valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end
    assign m_tvalid = valid_reg[LAT-1];

    // Stage 1: the nine products of the quaternion components.
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    // Stage 2: sine and cosine terms for the three angles.
    logic signed [SUM_W-1:0] sinr_reg, cosr_reg, siny_reg, cosy_reg, sinp_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sinr_reg <= (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
            cosr_reg <= ONE - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
            siny_reg <= (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
            cosy_reg <= ONE - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
            sinp_reg <= (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        end
    end

    // Roll and yaw go straight into their atan2 units.
    logic [15:0] roll_a, yaw_a;

    q2e_atan2 #(
        .IN_W(SUM_W), .OUT_W(16), .LIM_DEG(180), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_roll (
        .aclk(aclk), .en(en), .y_in(sinr_reg), .x_in(cosr_reg), .angle_out(roll_a)
    );

    q2e_atan2 #(
        .IN_W(SUM_W), .OUT_W(16), .LIM_DEG(180), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_yaw (
        .aclk(aclk), .en(en), .y_in(siny_reg), .x_in(cosy_reg), .angle_out(yaw_a)
    );

    // Pitch, stage 3: saturation test and the sine magnitude at 30 fraction bits.
    logic [SUM_W-1:0]     mag_p, mag_s;
    logic [WORK_BITS-1:0] m30_reg, m30_4_reg, m30_5_reg;
    logic                 sat_reg, sat_4_reg, sat_5_reg;
    logic                 neg_reg, neg_4_reg, neg_5_reg;

    always_comb begin
        mag_p = sinp_reg[SUM_W-1] ? SUM_W'(-sinp_reg) : SUM_W'(sinp_reg);
        mag_s = (mag_p >> SH_R) << SH_L;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m30_reg <= mag_s[WORK_BITS-1:0];
            sat_reg <= (mag_p >= SUM_W'(ONE));
            neg_reg <= sinp_reg[SUM_W-1];
        end
    end

    // Stage 4: square of the sine. Stage 5: one minus that square.
    logic [2*WORK_BITS-1:0] sq_reg;
    logic [2*WORK_BITS:0]   n_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= m30_reg * m30_reg;
            m30_4_reg <= m30_reg;
            sat_4_reg <= sat_reg;
            neg_4_reg <= neg_reg;
            n_reg     <= ((2 * WORK_BITS + 1)'(1) << (2 * WORK_BITS)) - (2 * WORK_BITS + 1)'(sq_reg);
            m30_5_reg <= m30_4_reg;
            sat_5_reg <= sat_4_reg;
            neg_5_reg <= neg_4_reg;
        end
    end

    // The cosine of pitch is the square root of one minus the squared sine.
    logic [WORK_BITS:0] cos_p;
    q2e_isqrt u_isqrt (.aclk(aclk), .en(en), .n_in(n_reg), .root_out(cos_p));

    // The sine magnitude waits alongside the square root.
    logic [WORK_BITS-1:0] m30_d_reg [ISQRT_STEPS];
    logic                 sat_d_reg [DELAY_SAT];
    logic                 neg_d_reg [DELAY_SAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            m30_d_reg[0] <= m30_5_reg;
            for (int i = 1; i < ISQRT_STEPS; i++) m30_d_reg[i] <= m30_d_reg[i-1];
            sat_d_reg[0] <= sat_5_reg;
            neg_d_reg[0] <= neg_5_reg;
            for (int i = 1; i < DELAY_SAT; i++) begin
                sat_d_reg[i] <= sat_d_reg[i-1];
                neg_d_reg[i] <= neg_d_reg[i-1];
            end
        end
    end

    logic signed [SUM_W-1:0] ps_y, ps_x;
    logic [14:0]             pitch_a, pitch_f;
    assign ps_y = neg_d_reg[ISQRT_STEPS-1] ? -SUM_W'(m30_d_reg[ISQRT_STEPS-1])
                                           : SUM_W'(m30_d_reg[ISQRT_STEPS-1]);
    assign ps_x = SUM_W'(cos_p);

    q2e_atan2 #(
        .IN_W(SUM_W), .OUT_W(15), .LIM_DEG(90), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_pitch (
        .aclk(aclk), .en(en), .y_in(ps_y), .x_in(ps_x), .angle_out(pitch_a)
    );

    // When the sine reached one, pitch is clamped to a right angle with the sine's sign.
    always_comb begin
        if (sat_d_reg[DELAY_SAT-1]) begin
            pitch_f = neg_d_reg[DELAY_SAT-1] ? 15'(-PITCH_LIM) : PITCH_LIM;
        end else begin
            pitch_f = pitch_a;
        end
    end

    // Roll and yaw finish earlier and wait for the pitch path.
    logic [15:0] roll_d_reg [DELAY_RY];
    logic [15:0] yaw_d_reg  [DELAY_RY];
    always_ff @(posedge aclk) begin
        if (en) begin
            roll_d_reg[0] <= roll_a;
            yaw_d_reg[0]  <= yaw_a;
            for (int i = 1; i < DELAY_RY; i++) begin
                roll_d_reg[i] <= roll_d_reg[i-1];
                yaw_d_reg[i]  <= yaw_d_reg[i-1];
            end
        end
    end

    assign m_tdata = {1'b0, roll_d_reg[DELAY_RY-1], pitch_f, yaw_d_reg[DELAY_RY-1]};
    assign m_tuser = sat_d_reg[DELAY_SAT-1];

endmodule

// ===== rtl/q2e_checker.sv =====
// Port-level checks for the quaternion to Euler angle converter, bound to the top level.
// Depends on quaternion_to_euler_zyx.
module q2e_checker #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    localparam logic [14:0] PITCH_LIM = 15'(longint'(90) << ANGLE_FRAC_BITS);

    // No result request is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result request valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is taken exactly when the output register is free or draining.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    // A saturated pitch is a right angle.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:16] == PITCH_LIM
                             || m_tdata[30:16] == 15'(-PITCH_LIM))
        else $error("saturated pitch is not a right angle");

endmodule

bind quaternion_to_euler_zyx q2e_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_q2e_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== tb/euler_checker.sv =====
// Scoreboard for the quaternion to Z-Y-X Euler angle converter.
// Watches both stream channels, computes the expected angles and compares them.
// Depends on nothing; bit-exact fixed-point model held locally.
`timescale 1ns / 100ps
module euler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          saturated_seen
);

    localparam int QFRAC = 14;
    localparam int AFRAC = 7;
    localparam int WBITS = 30;
    localparam int STEPS = 31;
    localparam longint QUARTER = 64'sd1 << 30;

    typedef struct packed {
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [15:0] roll;
        logic        sat;
    } angles_t;

    localparam longint ARCTAN_STEP [STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1
    };

    angles_t expected_angles [$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC, angle in units of 2^-32 turn.
    function automatic longint arctan2_turns(longint sy, longint sx);
        longint unsigned ux, uy, mx;
        longint cx, cy, z, t, dx, dy;
        ux = sx < 0 ? -sx : sx;
        uy = sy < 0 ? -sy : sy;
        mx = ux > uy ? ux : uy;
        z = 0;
        if (mx == 0) return 0;
        while (mx >= (64'd1 << WBITS)) begin
            ux = ux >> 1; uy = uy >> 1; mx = mx >> 1;
        end
        while (mx < (64'd1 << (WBITS - 1))) begin
            ux = ux << 1; uy = uy << 1; mx = mx << 1;
        end
        cx = sx < 0 ? -longint'(ux) : longint'(ux);
        cy = sy < 0 ? -longint'(uy) : longint'(uy);
        if (cx < 0) begin
            if (cy >= 0) begin
                z = QUARTER; t = cx; cx = cy; cy = -t;
            end else begin
                z = -QUARTER; t = cx; cx = -cy; cy = t;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx = cx + dx; cy = cy - dy; z = z + ARCTAN_STEP[i];
            end else begin
                cx = cx - dx; cy = cy + dy; z = z - ARCTAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic longint turns_to_degrees(longint a, longint limit_deg);
        longint r, lim;
        r = (a * 360 * (64'sd1 << AFRAC) + (64'sd1 << 31)) >>> 32;
        lim = limit_deg * (64'sd1 << AFRAC);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic angles_t euler_from_quat(logic [63:0] q);
        longint w, x, y, z, one, sinr, cosr, siny, cosy, sinp, s30, pitch_t;
        longint unsigned m, c;
        angles_t a;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        one = 64'sd1 << (2 * QFRAC);
        sinr = 2 * (w * x + y * z);
        cosr = one - 2 * (x * x + y * y);
        siny = 2 * (w * z + x * y);
        cosy = one - 2 * (y * y + z * z);
        sinp = 2 * (w * y - z * x);
        m = sinp < 0 ? -sinp : sinp;
        a.sat = (m >= one);
        if (a.sat) begin
            pitch_t = sinp > 0 ? QUARTER : -QUARTER;
        end else begin
            m = m << (WBITS - 2 * QFRAC);
            s30 = sinp < 0 ? -longint'(m) : longint'(m);
            c = int_sqrt((64'd1 << (2 * WBITS)) - m * m);
            pitch_t = arctan2_turns(s30, longint'(c));
        end
        a.yaw   = 16'(turns_to_degrees(arctan2_turns(siny, cosy), 180));
        a.pitch = 15'(turns_to_degrees(pitch_t, 90));
        a.roll  = 16'(turns_to_degrees(arctan2_turns(sinr, cosr), 180));
        return a;
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        results_seen = 0;
        saturated_seen = 0;
    end

    always @(posedge aclk) begin
        angles_t e;
        if (aresetn && s_tvalid && s_tready)
            expected_angles.push_back(euler_from_quat(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) saturated_seen++;
            if (expected_angles.size() == 0) begin
                $error("result with no request outstanding: tdata=%h", m_tdata);
                errors++;
            end else begin
                e = expected_angles.pop_front();
                if (m_tdata[15:0] !== e.yaw) begin
                    $error("yaw_angle: expected %0d, got %0d",
                           $signed(e.yaw), $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[30:16] !== e.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d",
                           $signed(e.pitch), $signed(m_tdata[30:16]));
                    errors++;
                end
                if (m_tdata[46:31] !== e.roll) begin
                    $error("roll_angle: expected %0d, got %0d",
                           $signed(e.roll), $signed(m_tdata[46:31]));
                    errors++;
                end
                if (m_tdata[47] !== 1'b0) begin
                    $error("padding: expected 0, got %b", m_tdata[47]);
                    errors++;
                end
                if (m_tuser !== e.sat) begin
                    $error("pitch_saturated: expected %b, got %b", e.sat, m_tuser);
                    errors++;
                end
            end
        end
        pending <= expected_angles.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top level of the quaternion to Euler angle converter testbench.
// Drives requests and back-pressure; depends on quaternion_to_euler_zyx and euler_checker.
`timescale 1ns / 100ps
module testbench;

    localparam int LATENCY = 73;
    localparam int RANDOM_REQUESTS = 500;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    int errors, pending, results_seen, saturated_seen;
    int requests_sent = 0;
    bit stimulus_done = 0;

    always #2 aclk = ~aclk;

    quaternion_to_euler_zyx dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    euler_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending),
        .results_seen(results_seen), .saturated_seen(saturated_seen)
    );

    // The receiver stalls on its own pattern. It draws among ready, a random value
    // and not ready, so that gaps fall on every stage.
    always @(posedge aclk) begin
        int mode;
        mode = $urandom_range(0, 99);
        if (!aresetn)
            m_tready <= 1'b0;
        else if (stimulus_done && pending == 0)
            m_tready <= 1'b1;
        else if (mode < 45)
            m_tready <= 1'b1;
        else if (mode < 85)
            m_tready <= $urandom_range(0, 1);
        else
            m_tready <= 1'b0;
    end

    // Presents one request and holds it until the block takes it. The valid
    // stays high, so back-to-back requests within a burst follow without a gap.
    task automatic send_quat(input logic [15:0] w, x, y, z);
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x, w};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // One random quaternion. Most are of the size a real orientation has,
    // some sit on the gimbal-lock boundary and the rest use the full range.
    task automatic send_random_quat();
        int kind;
        logic [15:0] w, x, y, z;
        kind = $urandom_range(0, 9);
        w = 16'($urandom_range(0, 32768) - 16384);
        x = 16'($urandom_range(0, 32768) - 16384);
        y = 16'($urandom_range(0, 32768) - 16384);
        z = 16'($urandom_range(0, 32768) - 16384);
        if (kind < 2) begin
            // Near the pitch clamp: w*y close to plus or minus one half, small x and z.
            w = 16'(11585 + $urandom_range(0, 8) - 4);
            y = $urandom_range(0, 1) ? 16'(11585 + $urandom_range(0, 8) - 4)
                                     : 16'(-11585 - $urandom_range(0, 8) + 4);
            x = 16'($urandom_range(0, 6) - 3);
            z = 16'($urandom_range(0, 6) - 3);
        end else if (kind < 4) begin
            w = 16'($urandom);
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        send_quat(w, x, y, z);
    endtask

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int burst;
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity, half turns about each axis, the zero quaternion and the negated identity
        // (the zero quaternion gives each atan2 the same operands as the identity).
        send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
        send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
        send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
        send_quat(16'd0, 16'd0, 16'd0, 16'd0);
        send_quat(-16'sd16384, 16'd0, 16'd0, 16'd0);
        // Pitch just below and at or past plus and minus ninety degrees.
        send_quat(16'd11585, 16'd0, 16'd11585, 16'd0);
        send_quat(16'd11586, 16'd0, 16'd11586, 16'd0);
        send_quat(16'd11586, 16'd0, -16'sd11586, 16'd0);
        send_quat(16'd0, 16'd11586, 16'd0, -16'sd11586);
        // Field extremes and non-unit values.
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h8000, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        // Ordinary rotations: quarter turns about x and about z and a third of a turn about the diagonal.
        send_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
        send_quat(16'd11585, 16'd0, 16'd0, -16'sd11585);
        send_quat(16'd8192, 16'd8192, 16'd8192, 16'd8192);

        for (int n = 0; n < RANDOM_REQUESTS; ) begin
            pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++)
                send_random_quat();
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending != 0) begin
            $display("FAILURE");
            $finish;
        end
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Sent %0d quaternions, checked %0d angle results, %0d of them with pitch clamped.",
                 requests_sent, results_seen, saturated_seen);
        $display("Random bursts and receiver stalls exercised the pipeline hold path.");
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
